@@ sv/pid_regulator_two_mode_macros.svh @@
// Assertion macros for the two-mode PID regulator checks.
// Taken in by the checker file; no other dependencies.
`ifndef PID_REGULATOR_TWO_MODE_MACROS_SVH
`define PID_REGULATOR_TWO_MODE_MACROS_SVH

// property checked on every edge, reset included
`define PIDR2M_ASSERT(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("pid regulator check failed");

// property checked outside reset only
`define PIDR2M_ASSERT_RUN(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pid regulator check failed");

`endif

@@ sv/pidr2m_pkg.sv @@
// Shared types and constants of the two-mode PID regulator.
// No dependencies; imported by every design file and by the interface file.
package pidr2m_pkg;

  localparam int GAIN_WIDTH      = 16;
  localparam int LIMIT_WIDTH     = 15;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MODE      = 3'd0,
    REG_PROP_GAIN = 3'd1,
    REG_INT_GAIN  = 3'd2,
    REG_DER_GAIN  = 3'd3,
    REG_INT_LIMIT = 3'd4,
    REG_OUT_LIMIT = 3'd5
  } cfg_index_t;

  // mode: 0 positional, 1 incremental
  typedef struct packed {
    logic                   mode;
    logic [GAIN_WIDTH-1:0]  kp;
    logic [GAIN_WIDTH-1:0]  ki;
    logic [GAIN_WIDTH-1:0]  kd;
    logic [LIMIT_WIDTH-1:0] ilim;
    logic [LIMIT_WIDTH-1:0] olim;
  } cfg_t;

endpackage

@@ sv/pidr2m_if.sv @@
// Channel interfaces of the two-mode PID regulator: samples, results, config writes.
// Depends on pidr2m_pkg for the config field widths.
interface pidr2m_in_if #(parameter int DATA_WIDTH = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measured;
  logic signed [DATA_WIDTH-1:0] setpoint;

  modport source (output valid, output measured, output setpoint, input ready);
  modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

interface pidr2m_out_if #(parameter int DATA_WIDTH = 16) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive;
  logic                         saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink   (input valid, input drive, input saturated, output ready);
endinterface

interface pidr2m_cfg_if import pidr2m_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/pidr2m_cfg.sv @@
// Configuration register bank of the two-mode PID regulator.
// Depends on pidr2m_pkg and the config interface.
module pidr2m_cfg import pidr2m_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pidr2m_cfg_if.sink   cfg,
  output cfg_t         regs
);

  cfg_t regs_next;

  assign cfg.ready = 1'b1;

  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        REG_MODE:      regs_next.mode = cfg.data[0];
        REG_PROP_GAIN: regs_next.kp   = cfg.data[GAIN_WIDTH-1:0];
        REG_INT_GAIN:  regs_next.ki   = cfg.data[GAIN_WIDTH-1:0];
        REG_DER_GAIN:  regs_next.kd   = cfg.data[GAIN_WIDTH-1:0];
        REG_INT_LIMIT: regs_next.ilim = cfg.data[LIMIT_WIDTH-1:0];
        REG_OUT_LIMIT: regs_next.olim = cfg.data[LIMIT_WIDTH-1:0];
        default:       regs_next = regs;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else begin
      regs <= regs_next;
    end
  end

endmodule

@@ sv/pidr2m_front.sv @@
// Front stage: sample register, error and its differences, the three gain products.
// Depends on pidr2m_pkg and the sample interface.
module pidr2m_front import pidr2m_pkg::*; #(
  parameter  int DATA_WIDTH = 16,
  localparam int MW         = DATA_WIDTH + GAIN_WIDTH + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  pidr2m_in_if.sink            sample,
  input  cfg_t                 regs,
  input  logic                 adv,
  output logic                 prod_valid,
  output logic signed [MW-1:0] prod_p,
  output logic signed [MW-1:0] prod_i,
  output logic signed [MW-1:0] prod_d
);

  localparam int EW   = DATA_WIDTH + 1;
  localparam int DEW  = DATA_WIDTH + 2;
  localparam int DDEW = DATA_WIDTH + 3;

  logic                         s1_valid;
  logic signed [DATA_WIDTH-1:0] meas;
  logic signed [DATA_WIDTH-1:0] setp;
  logic signed [EW-1:0]         prev_err;
  logic signed [EW-1:0]         older_err;

  logic signed [EW-1:0]         err;
  logic signed [DEW-1:0]        derr;
  logic signed [DDEW-1:0]       dderr;
  logic signed [DDEW-1:0]       op_p;
  logic signed [DDEW-1:0]       op_i;
  logic signed [DDEW-1:0]       op_d;
  logic signed [GAIN_WIDTH:0]   kp_s;
  logic signed [GAIN_WIDTH:0]   ki_s;
  logic signed [GAIN_WIDTH:0]   kd_s;
  logic signed [MW-1:0]         mul_p;
  logic signed [MW-1:0]         mul_i;
  logic signed [MW-1:0]         mul_d;

  assign sample.ready = adv;

  always_comb begin
    err   = EW'(setp) - EW'(meas);
    derr  = DEW'(err) - DEW'(prev_err);
    dderr = DDEW'(err) - DDEW'(prev_err) - DDEW'(prev_err) + DDEW'(older_err);
    // positional: kp*e, kd*de; incremental: kp*de, kd*dde
    op_p  = regs.mode ? DDEW'(derr) : DDEW'(err);
    op_i  = DDEW'(err);
    op_d  = regs.mode ? dderr : DDEW'(derr);
    kp_s  = $signed({1'b0, regs.kp});
    ki_s  = $signed({1'b0, regs.ki});
    kd_s  = $signed({1'b0, regs.kd});
    mul_p = op_p * kp_s;
    mul_i = op_i * ki_s;
    mul_d = op_d * kd_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      prod_valid <= 1'b0;
      prev_err   <= '0;
      older_err  <= '0;
    end else if (adv) begin
      s1_valid   <= sample.valid;
      prod_valid <= s1_valid;
      if (s1_valid) begin
        older_err <= prev_err;
        prev_err  <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sample.valid) begin
      meas <= sample.measured;
      setp <= sample.setpoint;
    end
    if (adv && s1_valid) begin
      prod_p <= mul_p;
      prod_i <= mul_i;
      prod_d <= mul_d;
    end
  end

endmodule

@@ sv/pidr2m_accum.sv @@
// Back stage: integral and running sums, both clamps, truncation, result register.
// Depends on pidr2m_pkg and the result interface.
module pidr2m_accum import pidr2m_pkg::*; #(
  parameter  int DATA_WIDTH     = 16,
  parameter  int GAIN_FRAC_BITS = 8,
  localparam int MW             = DATA_WIDTH + GAIN_WIDTH + 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 regs,
  input  logic                 prod_valid,
  input  logic signed [MW-1:0] prod_p,
  input  logic signed [MW-1:0] prod_i,
  input  logic signed [MW-1:0] prod_d,
  pidr2m_out_if.source         result,
  output logic                 adv
);

  localparam int STW = LIMIT_WIDTH + GAIN_FRAC_BITS + 2;
  localparam int SW  = (MW + 2 > STW + 2) ? MW + 2 : STW + 2;

  logic                         out_valid;
  logic signed [DATA_WIDTH-1:0] out_drive;
  logic                         out_sat;
  logic signed [STW-1:0]        integral_sum;
  logic signed [STW-1:0]        running_output;

  logic signed [SW-1:0] ilim_s;
  logic signed [SW-1:0] olim_s;
  logic signed [SW-1:0] int_pre;
  logic signed [SW-1:0] int_new;
  logic signed [SW-1:0] base;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] run_new;
  logic                 out_hit;
  logic signed [SW-1:0] mag;
  logic signed [SW-1:0] quo;
  logic signed [SW-1:0] trunc_val;

  function automatic logic signed [SW-1:0] clamp_abs(input logic signed [SW-1:0] x,
                                                     input logic signed [SW-1:0] lim);
    logic signed [SW-1:0] r;
    r = x;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  assign adv          = !(out_valid && !result.ready);
  assign result.valid = out_valid;
  assign result.drive = out_drive;
  assign result.saturated = out_sat;

  always_comb begin
    ilim_s  = $signed(SW'(regs.ilim) << GAIN_FRAC_BITS);
    olim_s  = $signed(SW'(regs.olim) << GAIN_FRAC_BITS);
    // incremental mode bounds the single ki*e term, positional the accumulated one
    int_pre = regs.mode ? SW'(prod_i) : SW'(integral_sum) + SW'(prod_i);
    int_new = clamp_abs(int_pre, ilim_s);
    base    = regs.mode ? SW'(running_output) : '0;
    sum     = base + SW'(prod_p) + int_new + SW'(prod_d);
    run_new = clamp_abs(sum, olim_s);
    out_hit = (sum > olim_s) || (sum < -olim_s);
    // truncate toward zero
    mag       = run_new[SW-1] ? -run_new : run_new;
    quo       = mag >> GAIN_FRAC_BITS;
    trunc_val = run_new[SW-1] ? -quo : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      integral_sum   <= '0;
      running_output <= '0;
    end else if (adv) begin
      out_valid <= prod_valid;
      if (prod_valid) begin
        integral_sum   <= int_new[STW-1:0];
        running_output <= run_new[STW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && prod_valid) begin
      out_drive <= trunc_val[DATA_WIDTH-1:0];
      out_sat   <= out_hit;
    end
  end

endmodule

@@ sv/pid_regulator_two_mode.sv @@
// Two-mode PID regulator, positional or incremental, fixed-point gains.
// Channels: sample (sink) takes measured/setpoint, result (source) gives drive and
// saturated, cfg (sink) writes the six registers by index; all are valid/ready.
// One result per sample, in order. Pipeline of three register stages: sample
// register, product register (three gain multipliers), result register holding the
// clamped sum. Throughput is one sample per cycle while results are being taken;
// the integral and running-sum update is combinational within the back stage.
// cfg.ready is always high; registers are meant to be written with the pipe empty.
// While result is valid and not taken, the whole pipe holds and sample.ready is
// low; it rises again the cycle the result is taken, so nothing is lost.
// Synchronous reset empties the pipe and clears registers, error history, integral
// and running output to zero.
// Depends on pidr2m_pkg, pidr2m_if, pidr2m_cfg, pidr2m_front, pidr2m_accum.
module pid_regulator_two_mode import pidr2m_pkg::*; #(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  pidr2m_in_if.sink     sample,
  pidr2m_out_if.source  result,
  pidr2m_cfg_if.sink    cfg
);

  localparam int MW = DATA_WIDTH + GAIN_WIDTH + 4;

  cfg_t                 regs;
  logic                 adv;
  logic                 prod_valid;
  logic signed [MW-1:0] prod_p;
  logic signed [MW-1:0] prod_i;
  logic signed [MW-1:0] prod_d;

  pidr2m_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pidr2m_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .regs       (regs),
    .adv        (adv),
    .prod_valid (prod_valid),
    .prod_p     (prod_p),
    .prod_i     (prod_i),
    .prod_d     (prod_d)
  );

  pidr2m_accum #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .prod_valid (prod_valid),
    .prod_p     (prod_p),
    .prod_i     (prod_i),
    .prod_d     (prod_d),
    .result     (result),
    .adv        (adv)
  );

endmodule

@@ sv/pidr2m_chk.sv @@
// Port-level checks of the two-mode PID regulator, bound to the top level.
// Depends on pid_regulator_two_mode_macros.svh.
`include "pid_regulator_two_mode_macros.svh"

module pidr2m_chk #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] drive,
  input logic                         saturated,
  input logic                         cfg_ready
);

  // result on offer and not taken this cycle
  logic stall;

  assign stall = out_valid && !out_ready;

  // reset leaves no result pending
  `PIDR2M_ASSERT(a_rst_empty, clk, rst |=> !out_valid)
  // a waiting result is not altered
  `PIDR2M_ASSERT_RUN(a_hold, clk, rst, stall |=> out_valid && $stable({drive, saturated}))
  // input is held off only by a result that is not being taken
  `PIDR2M_ASSERT_RUN(a_in_ready, clk, rst, in_ready == !stall)
  // config writes are never refused
  `PIDR2M_ASSERT_RUN(a_cfg_ready, clk, rst, cfg_ready)

endmodule

bind pid_regulator_two_mode pidr2m_chk #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .drive     (result.drive),
  .saturated (result.saturated),
  .cfg_ready (cfg.ready)
);
